FILE: hw/rtl/hsvtc_pkg.sv
// Shared types and constants for the HSV threshold blob centroid core.
// Used by the front, queue, back and top-level modules; depends on nothing.
package hsvtc_pkg;

  localparam int ChanW     = 8;
  localparam int CoordW    = 10;
  localparam int AreaW     = 21;
  localparam int SumW      = 30;
  localparam int RadW      = 10;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 8;
  localparam int PiScaleW  = 17;
  localparam int PiW       = 19;
  localparam int LimitW    = AreaW + PiScaleW;
  localparam int ProdW     = 2 * RadW + PiW;

  localparam int MaxHeightDefault = 1024;
  localparam int MaxWidthDefault  = 1024;
  localparam int QueueDepth       = 2;

  localparam logic [AreaW-1:0]    CountMax = '1;
  localparam logic [SumW-1:0]     SumMax   = '1;
  localparam logic [PiScaleW-1:0] PiScale  = 17'd100000;
  localparam logic [PiW-1:0]      PiScaled = 19'd314159;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HUE_LOW  = 3'd0,
    CFG_HUE_HIGH = 3'd1,
    CFG_SAT_LOW  = 3'd2,
    CFG_SAT_HIGH = 3'd3,
    CFG_VAL_LOW  = 3'd4,
    CFG_VAL_HIGH = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic              mask;
    logic              last;
    logic [AreaW-1:0]  count;
    logic [SumW-1:0]   row_sum;
    logic [SumW-1:0]   col_sum;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic              mask;
    logic              frame_done;
    logic              object_found;
    logic [AreaW-1:0]  blob_area;
    logic [CoordW-1:0] center_row;
    logic [CoordW-1:0] center_col;
    logic [RadW-1:0]   blob_radius;
  } result_t;

endpackage

FILE: hw/rtl/hsvtc_front.sv
// Front end: configuration registers, per-pixel threshold test and frame accumulators.
// Pushes one queue entry per accepted pixel. Depends on hsvtc_pkg.
module hsvtc_front #(
  parameter int MAX_HEIGHT = hsvtc_pkg::MaxHeightDefault,
  parameter int MAX_WIDTH  = hsvtc_pkg::MaxWidthDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [hsvtc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hsvtc_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hsvtc_pkg::ChanW-1:0]     in_hue,
  input  logic [hsvtc_pkg::ChanW-1:0]     in_saturation,
  input  logic [hsvtc_pkg::ChanW-1:0]     in_brightness,
  input  logic [hsvtc_pkg::CoordW-1:0]    in_pixel_row,
  input  logic [hsvtc_pkg::CoordW-1:0]    in_pixel_col,
  input  logic                            in_last_pixel,
  input  hsvtc_pkg::queue_status_t        q_status,
  output logic                            q_push,
  output hsvtc_pkg::entry_t               q_entry
);
  import hsvtc_pkg::*;

  logic [ChanW-1:0] hue_low_r, hue_high_r, sat_low_r, sat_high_r, val_low_r, val_high_r;
  logic [AreaW-1:0] count_r, count_nxt;
  logic [SumW-1:0]  row_sum_r, row_sum_nxt, col_sum_r, col_sum_nxt;
  logic [SumW:0]    row_add, col_add;
  logic             in_frame, hit, accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  assign in_frame = (32'(in_pixel_row) < 32'(MAX_HEIGHT)) &&
                    (32'(in_pixel_col) < 32'(MAX_WIDTH));
  assign hit = in_frame &&
               (hue_low_r < in_hue) && (in_hue < hue_high_r) &&
               (sat_low_r < in_saturation) && (in_saturation < sat_high_r) &&
               (val_low_r < in_brightness) && (in_brightness < val_high_r);

  assign row_add = {1'b0, row_sum_r} + (SumW + 1)'(in_pixel_row);
  assign col_add = {1'b0, col_sum_r} + (SumW + 1)'(in_pixel_col);

  always_comb begin
    count_nxt   = count_r;
    row_sum_nxt = row_sum_r;
    col_sum_nxt = col_sum_r;
    if (hit) begin
      count_nxt   = (count_r == CountMax) ? count_r : count_r + AreaW'(1);
      row_sum_nxt = row_add[SumW] ? SumMax : row_add[SumW-1:0];
      col_sum_nxt = col_add[SumW] ? SumMax : col_add[SumW-1:0];
    end
  end

  assign q_push          = accept;
  assign q_entry.mask    = hit;
  assign q_entry.last    = in_last_pixel;
  assign q_entry.count   = count_nxt;
  assign q_entry.row_sum = row_sum_nxt;
  assign q_entry.col_sum = col_sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= '0;
      hue_high_r <= '0;
      sat_low_r  <= '0;
      sat_high_r <= '0;
      val_low_r  <= '0;
      val_high_r <= '0;
      count_r    <= '0;
      row_sum_r  <= '0;
      col_sum_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_HUE_LOW:  hue_low_r  <= cfg_wdata;
          CFG_HUE_HIGH: hue_high_r <= cfg_wdata;
          CFG_SAT_LOW:  sat_low_r  <= cfg_wdata;
          CFG_SAT_HIGH: sat_high_r <= cfg_wdata;
          CFG_VAL_LOW:  val_low_r  <= cfg_wdata;
          CFG_VAL_HIGH: val_high_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        if (in_last_pixel) begin
          count_r   <= '0;
          row_sum_r <= '0;
          col_sum_r <= '0;
        end else begin
          count_r   <= count_nxt;
          row_sum_r <= row_sum_nxt;
          col_sum_r <= col_sum_nxt;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/hsvtc_queue.sv
// Short queue between the front and back ends, holding classified pixel entries.
// Depends on hsvtc_pkg.
module hsvtc_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  hsvtc_pkg::entry_t         push_entry,
  input  logic                      pop,
  output hsvtc_pkg::entry_t         head,
  output hsvtc_pkg::queue_status_t  status
);
  import hsvtc_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  entry_t          mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push, do_pop;

  assign status.full  = (count_r == CntW'(QueueDepth));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/hsvtc_back.sv
// Back end: drains the queue into the output register and, on a frame's last pixel,
// runs the bit-serial centroid divides and the radius search. Depends on hsvtc_pkg.
module hsvtc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hsvtc_pkg::entry_t         head,
  input  hsvtc_pkg::queue_status_t  q_status,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output hsvtc_pkg::result_t        out_result
);
  import hsvtc_pkg::*;

  localparam int StepW = $clog2(SumW);
  localparam int KW    = $clog2(RadW) + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DONE} state_t;

  typedef struct packed {
    logic [AreaW:0]  rem;
    logic [SumW-1:0] quo;
  } div_state_t;

  function automatic div_state_t div_step(div_state_t s, logic [AreaW-1:0] dsr);
    logic [AreaW:0] sh;
    div_state_t     n;
    sh    = {s.rem[AreaW-1:0], s.quo[SumW-1]};
    n.quo = {s.quo[SumW-2:0], 1'b0};
    if (sh >= {1'b0, dsr}) begin
      n.rem    = sh - {1'b0, dsr};
      n.quo[0] = 1'b1;
    end else begin
      n.rem = sh;
    end
    return n;
  endfunction

  function automatic logic [CoordW-1:0] clamp_center(logic [SumW-1:0] q);
    return (q[SumW-1:CoordW] != '0) ? '1 : q[CoordW-1:0];
  endfunction

  state_t             state_r, state_nxt;
  logic [StepW-1:0]   step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            res_r, res_nxt;
  logic               mask_r, mask_nxt;
  logic [AreaW-1:0]   count_r, count_nxt;
  div_state_t         rdiv_r, rdiv_nxt, cdiv_r, cdiv_nxt;
  logic [LimitW-1:0]  limit_r, limit_nxt;
  logic [RadW-1:0]    rad_r, rad_nxt;
  logic [2*RadW-1:0]  sq_r, sq_nxt;
  logic [KW-1:0]      k;
  logic [RadW-1:0]    cand;
  logic [2*RadW-1:0]  cand_sq;
  logic [ProdW-1:0]   prod;
  logic               out_free, found;

  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_result = res_r;
  assign found      = (count_r != '0);

  assign k       = KW'(RadW - 1) - KW'(step_r);
  assign cand    = rad_r | (RadW'(1) << k);
  assign cand_sq = sq_r + ((2 * RadW)'(rad_r) << (k + KW'(1))) + ((2 * RadW)'(1) << {k, 1'b0});
  assign prod    = ProdW'(cand_sq) * ProdW'(PiScaled);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    mask_nxt      = mask_r;
    count_nxt     = count_r;
    rdiv_nxt      = rdiv_r;
    cdiv_nxt      = cdiv_r;
    limit_nxt     = limit_r;
    rad_nxt       = rad_r;
    sq_nxt        = sq_r;
    q_pop         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_status.empty && head.last) begin
          q_pop         = 1'b1;
          mask_nxt      = head.mask;
          count_nxt     = head.count;
          rdiv_nxt.rem  = '0;
          rdiv_nxt.quo  = head.row_sum;
          cdiv_nxt.rem  = '0;
          cdiv_nxt.quo  = head.col_sum;
          limit_nxt     = LimitW'(head.count) * LimitW'(PiScale);
          rad_nxt       = '0;
          sq_nxt        = '0;
          step_nxt      = '0;
          state_nxt     = ST_CALC;
        end else if (!q_status.empty && out_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          res_nxt.mask  = head.mask;
        end
      end
      ST_CALC: begin
        rdiv_nxt = div_step(rdiv_r, count_r);
        cdiv_nxt = div_step(cdiv_r, count_r);
        if (step_r < StepW'(RadW)) begin
          if (prod <= ProdW'(limit_r)) begin
            rad_nxt = cand;
            sq_nxt  = cand_sq;
          end
        end
        if (step_r == StepW'(SumW - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + StepW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          res_nxt.mask         = mask_r;
          res_nxt.frame_done   = 1'b1;
          res_nxt.object_found = found;
          res_nxt.blob_area    = count_r;
          res_nxt.center_row   = found ? clamp_center(rdiv_r.quo) : '0;
          res_nxt.center_col   = found ? clamp_center(cdiv_r.quo) : '0;
          res_nxt.blob_radius  = rad_r;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r   <= res_nxt;
    mask_r  <= mask_nxt;
    count_r <= count_nxt;
    rdiv_r  <= rdiv_nxt;
    cdiv_r  <= cdiv_nxt;
    limit_r <= limit_nxt;
    rad_r   <= rad_nxt;
    sq_r    <= sq_nxt;
  end

endmodule

FILE: hw/rtl/hsv_threshold_blob_centroid_core.sv
// HSV threshold blob centroid core: front end, two-entry queue and back end.
// A result is registered in the queue and then in the output register; the last pixel
// of a frame also waits for the one-bit-per-cycle 30-step centroid divide.
// Throughput: one pixel per cycle when not stalled; a frame end holds the back end busy.
// Reset (synchronous, rst_n low) clears the bounds, the accumulators, the queue and the
// output valid flag.
module hsv_threshold_blob_centroid_core #(
  parameter int MAX_HEIGHT = hsvtc_pkg::MaxHeightDefault,
  parameter int MAX_WIDTH  = hsvtc_pkg::MaxWidthDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [hsvtc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hsvtc_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hsvtc_pkg::ChanW-1:0]     in_hue,
  input  logic [hsvtc_pkg::ChanW-1:0]     in_saturation,
  input  logic [hsvtc_pkg::ChanW-1:0]     in_brightness,
  input  logic [hsvtc_pkg::CoordW-1:0]    in_pixel_row,
  input  logic [hsvtc_pkg::CoordW-1:0]    in_pixel_col,
  input  logic                            in_last_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_mask,
  output logic                            out_frame_done,
  output logic                            out_object_found,
  output logic [hsvtc_pkg::AreaW-1:0]     out_blob_area,
  output logic [hsvtc_pkg::CoordW-1:0]    out_center_row,
  output logic [hsvtc_pkg::CoordW-1:0]    out_center_col,
  output logic [hsvtc_pkg::RadW-1:0]      out_blob_radius
);
  import hsvtc_pkg::*;

  queue_status_t q_status;
  entry_t        q_entry, q_head;
  logic          q_push, q_pop;
  result_t       result;

  hsvtc_front #(
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .in_pixel_row (in_pixel_row),
    .in_pixel_col (in_pixel_col),
    .in_last_pixel(in_last_pixel),
    .q_status     (q_status),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  hsvtc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  hsvtc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_result(result)
  );

  assign out_mask         = result.mask;
  assign out_frame_done   = result.frame_done;
  assign out_object_found = result.object_found;
  assign out_blob_area    = result.blob_area;
  assign out_center_row   = result.center_row;
  assign out_center_col   = result.center_col;
  assign out_blob_radius  = result.blob_radius;

endmodule
